@@ src/windowed_signal_statistics_top_defines.svh @@
// Assertion macros for the block's top level.
`ifndef WINDOWED_SIGNAL_STATISTICS_TOP_DEFINES_SVH
`define WINDOWED_SIGNAL_STATISTICS_TOP_DEFINES_SVH
// Checks that an implication holds at every clock edge outside reset.
`define WSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Checks that a condition holds in the cycle after an antecedent.
`define WSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ src/wss_pkg.sv @@
// ----------------------------------------------------------------------------
// Windowed statistics package
// Shared types and constants for the windowed signal statistics block.
// ----------------------------------------------------------------------------
package wss_pkg;
  localparam int unsigned CapDefault = 128;
  localparam logic [31:0] WindowTicksReset = 32'd100;
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [31:0]        sample_time;
    logic signed [15:0] sample_value;
  } in_req_t;

  typedef struct packed {
    logic               window_closed;
    logic signed [15:0] mean_value;
    logic [15:0]        rms_value;
    logic signed [15:0] min_value;
    logic signed [15:0] max_value;
    logic [7:0]         sample_count;
    logic signed [15:0] instant_value;
  } out_req_t;
endpackage

@@ src/wss_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module wss_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end
endmodule

@@ src/wss_fifo.sv @@
// ----------------------------------------------------------------------------
// Result queue
// Small register queue that holds finished results for the receiver.
// ----------------------------------------------------------------------------
module wss_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  wss_pkg::out_req_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output wss_pkg::out_req_t pop_data
);
  import wss_pkg::*;

  out_req_t   slot_r [QueueDepth];
  logic [0:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full = (count_r == 2'(QueueDepth));
  assign empty = (count_r == 2'd0);
  assign pop_data = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end
endmodule

@@ src/wss_front.sv @@
// ----------------------------------------------------------------------------
// Statistics front end
// Accepts samples, decides window close, stores samples, sweeps the store.
// ----------------------------------------------------------------------------
module wss_front #(
  parameter int unsigned CAP = wss_pkg::CapDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata,
  input  logic                in_push,
  input  wss_pkg::in_req_t    in_data,
  output logic                in_full,
  output logic                job_valid,
  input  logic                job_ready,
  output logic                job_closed,
  output logic signed [47:0]  job_sum,
  output logic [47:0]         job_sumsq,
  output logic signed [15:0]  job_min,
  output logic signed [15:0]  job_max,
  output logic [$clog2(CAP+1)-1:0] job_count,
  output logic signed [15:0]  job_instant
);
  import wss_pkg::*;

  localparam int unsigned AW = $clog2(CAP);
  localparam int unsigned CW = $clog2(CAP + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_ACC   = 5'b00100,
    ST_STORE = 5'b01000,
    ST_SEND  = 5'b10000
  } st_t;

  st_t                st_r, st_nxt;
  logic [31:0]        ticks_r;
  logic [AW-1:0]      wp_r;
  logic [CW-1:0]      cnt_r;
  logic [31:0]        wstart_r;
  logic               started_r;
  in_req_t            req_r;
  logic               closed_r;
  logic [CW-1:0]      idx_r;
  logic [CW-1:0]      ncl_r;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic [15:0]        rd_data;
  logic signed [47:0] sum_r;
  logic [47:0]        sumsq_r;
  logic signed [15:0] min_r, max_r;
  logic               ram_we;
  logic [31:0]        wstart_eff, diff;
  logic               close_now;
  logic signed [15:0] rv;
  logic signed [31:0] sq;
  logic [AW:0]        addr_sum;

  assign in_full = (st_r != ST_IDLE);
  assign ram_we = (st_r == ST_STORE);
  assign wr_addr = closed_r ? '0 : wp_r;
  assign rv = signed'(rd_data);
  assign sq = rv * rv;

  always_comb begin
    wstart_eff = started_r ? wstart_r : in_data.sample_time;
    diff = in_data.sample_time - wstart_eff;
    close_now = (cnt_r != '0) && (in_data.sample_time >= wstart_eff) && (diff >= ticks_r);
    addr_sum = {1'b0, wp_r} + (AW+1)'(CAP) - (AW+1)'(ncl_r) + (AW+1)'(idx_r);
    if (addr_sum >= (AW+1)'(CAP)) begin
      addr_sum = addr_sum - (AW+1)'(CAP);
    end
    if (addr_sum >= (AW+1)'(CAP)) begin
      addr_sum = addr_sum - (AW+1)'(CAP);
    end
    rd_addr = addr_sum[AW-1:0];
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (in_push) begin
          st_nxt = close_now ? ST_READ : ST_STORE;
        end
      end
      ST_READ: st_nxt = ST_ACC;
      ST_ACC: st_nxt = (idx_r == ncl_r) ? ST_STORE : ST_READ;
      ST_STORE: st_nxt = ST_SEND;
      ST_SEND: begin
        if (job_ready) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  wss_ram #(.WIDTH(16), .DEPTH(CAP)) u_ram (
    .clk(clk), .wr_en(ram_we), .wr_addr(wr_addr), .wr_data(req_r.sample_value),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ticks_r <= WindowTicksReset;
      wp_r <= '0;
      cnt_r <= '0;
      wstart_r <= '0;
      started_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        ticks_r <= cfg_wdata;
      end
      if (st_r == ST_IDLE && in_push) begin
        started_r <= 1'b1;
        if (close_now) begin
          wstart_r <= wstart_eff + ticks_r;
        end else begin
          wstart_r <= wstart_eff;
        end
      end
      if (st_r == ST_STORE) begin
        if (closed_r) begin
          wp_r <= AW'(1);
          cnt_r <= CW'(1);
        end else begin
          wp_r <= (wp_r == AW'(CAP - 1)) ? '0 : wp_r + 1'b1;
          if (cnt_r != CW'(CAP)) begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        req_r <= in_data;
        closed_r <= close_now;
        idx_r <= '0;
        ncl_r <= cnt_r;
        sum_r <= '0;
        sumsq_r <= '0;
        min_r <= 16'sh7fff;
        max_r <= -16'sh8000;
      end
      ST_READ: idx_r <= idx_r + 1'b1;
      ST_ACC: begin
        sum_r <= sum_r + 48'(rv);
        sumsq_r <= sumsq_r + 48'(unsigned'(sq));
        if (rv < min_r) min_r <= rv;
        if (rv > max_r) max_r <= rv;
      end
      ST_STORE: ;
      ST_SEND: ;
      default: ;
    endcase
  end

  always_comb begin
    job_valid = (st_r == ST_SEND);
    job_closed = closed_r;
    job_sum = sum_r;
    job_sumsq = sumsq_r;
    job_min = min_r;
    job_max = max_r;
    job_count = ncl_r;
    job_instant = req_r.sample_value;
  end
endmodule

@@ src/wss_back.sv @@
// ----------------------------------------------------------------------------
// Statistics back end
// Divides sums by the count and takes the square root, one bit per cycle.
// ----------------------------------------------------------------------------
module wss_back #(
  parameter int unsigned CAP = wss_pkg::CapDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  output logic                job_ready,
  input  logic                job_closed,
  input  logic signed [47:0]  job_sum,
  input  logic [47:0]         job_sumsq,
  input  logic signed [15:0]  job_min,
  input  logic signed [15:0]  job_max,
  input  logic [$clog2(CAP+1)-1:0] job_count,
  input  logic signed [15:0]  job_instant,
  output logic                res_push,
  output wss_pkg::out_req_t   res_data,
  input  logic                res_full
);
  import wss_pkg::*;

  localparam int unsigned CW = $clog2(CAP + 1);

  typedef enum logic [4:0] {
    BS_IDLE = 5'b00001,
    BS_DIV1 = 5'b00010,
    BS_DIV2 = 5'b00100,
    BS_SQRT = 5'b01000,
    BS_OUT  = 5'b10000
  } bs_t;

  bs_t                st_r;
  logic               closed_r, neg_r;
  logic [47:0]        q1_r, r1_r, q2_r, r2_r;
  logic [47:0]        absum_r, sumsq_r;
  logic [CW-1:0]      cnt_r;
  logic [5:0]         bit_r;
  logic signed [15:0] min_r, max_r, inst_r;
  logic [47:0]        sv_r, res_r, sbit_r;
  logic [48:0]        t1, t2;
  logic [47:0]        quo_mean;
  logic [7:0]         cnt_sat;

  assign job_ready = (st_r == BS_IDLE);
  assign res_push = (st_r == BS_OUT) && !res_full;

  always_comb begin
    t1 = {r1_r, absum_r[bit_r]} - {1'b0, 48'(cnt_r)};
    t2 = {r2_r, sumsq_r[bit_r]} - {1'b0, 48'(cnt_r)};
    quo_mean = neg_r ? (48'd0 - q1_r) : q1_r;
    cnt_sat = (CW > 8 && cnt_r > CW'(255)) ? 8'd255 : 8'(cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BS_IDLE;
    end else begin
      case (st_r)
        BS_IDLE: if (job_valid) st_r <= job_closed ? BS_DIV1 : BS_OUT;
        BS_DIV1: if (bit_r == 6'd0) st_r <= BS_SQRT;
        BS_SQRT: if (sbit_r == 48'd1) st_r <= BS_OUT;
        BS_OUT: if (!res_full) st_r <= BS_IDLE;
        default: st_r <= BS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      BS_IDLE: begin
        closed_r <= job_closed;
        neg_r <= job_sum[47];
        absum_r <= job_sum[47] ? 48'(-job_sum) : 48'(job_sum);
        sumsq_r <= job_sumsq;
        cnt_r <= job_count;
        min_r <= job_min;
        max_r <= job_max;
        inst_r <= job_instant;
        q1_r <= '0;
        r1_r <= '0;
        q2_r <= '0;
        r2_r <= '0;
        bit_r <= 6'd47;
      end
      BS_DIV1: begin
        if (!t1[48]) begin
          r1_r <= t1[47:0];
          q1_r <= {q1_r[46:0], 1'b1};
        end else begin
          r1_r <= {r1_r[46:0], absum_r[bit_r]};
          q1_r <= {q1_r[46:0], 1'b0};
        end
        if (!t2[48]) begin
          r2_r <= t2[47:0];
          q2_r <= {q2_r[46:0], 1'b1};
        end else begin
          r2_r <= {r2_r[46:0], sumsq_r[bit_r]};
          q2_r <= {q2_r[46:0], 1'b0};
        end
        bit_r <= bit_r - 6'd1;
        if (bit_r == 6'd0) begin
          sv_r <= (!t2[48]) ? {q2_r[46:0], 1'b1} : {q2_r[46:0], 1'b0};
          res_r <= '0;
          sbit_r <= 48'd1 << 46;
        end
      end
      BS_SQRT: begin
        if (sv_r >= res_r + sbit_r) begin
          sv_r <= sv_r - (res_r + sbit_r);
          res_r <= (res_r >> 1) + sbit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        sbit_r <= sbit_r >> 2;
      end
      BS_DIV2: ;
      BS_OUT: ;
      default: ;
    endcase
  end

  always_comb begin
    res_data.window_closed = closed_r;
    res_data.mean_value = closed_r ? signed'(quo_mean[15:0]) : '0;
    res_data.rms_value = closed_r ? res_r[15:0] : '0;
    res_data.min_value = closed_r ? min_r : '0;
    res_data.max_value = closed_r ? max_r : '0;
    res_data.sample_count = closed_r ? cnt_sat : '0;
    res_data.instant_value = inst_r;
  end
endmodule

@@ src/windowed_signal_statistics_top.sv @@
// Windowed signal statistics, tumbling window mean, RMS, min and max.
// Input is a queue port: a request is taken when push is high and full low.
// Each request gives one result on the out_data queue port, read with pop
// while empty is low.
// The window length is written through cfg_we and cfg_wdata; the user must
// write it only while idle, as the block itself does not enforce this.
// A request that closes no window is stored and handed to the back end,
// and the input is free again once the back end has taken it.
// One that closes a window first sweeps the stored samples, then is handed
// off for bit-serial division, a square root and the output queue.
// The sweep of the sample RAM's single read port and the bit-serial
// divider set how long a request takes; the front end takes the next
// request while the back end still works on the previous one.
// Reset clears the window state and sets the length to 100 ticks.
// When the receiver stalls, two results wait in the output queue, one more
// in the back end and one in the front end, and then full stays high.
// ----------------------------------------------------------------------------
// Windowed signal statistics top level
// Front end, back end and result queue.
// ----------------------------------------------------------------------------
`include "windowed_signal_statistics_top_defines.svh"
module windowed_signal_statistics_top #(
  parameter int unsigned CAP = wss_pkg::CapDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata,
  input  logic              push,
  input  wss_pkg::in_req_t  in_data,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output wss_pkg::out_req_t out_data
);
  import wss_pkg::*;

  localparam int unsigned CW = $clog2(CAP + 1);

  logic               job_valid, job_ready, job_closed, res_push, res_full;
  logic signed [47:0] job_sum;
  logic [47:0]        job_sumsq;
  logic signed [15:0] job_min, job_max, job_instant;
  logic [CW-1:0]      job_count;
  out_req_t           res_data;

  wss_front #(.CAP(CAP)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_push(push), .in_data(in_data), .in_full(full),
    .job_valid(job_valid), .job_ready(job_ready), .job_closed(job_closed),
    .job_sum(job_sum), .job_sumsq(job_sumsq), .job_min(job_min), .job_max(job_max),
    .job_count(job_count), .job_instant(job_instant)
  );

  wss_back #(.CAP(CAP)) u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job_ready(job_ready),
    .job_closed(job_closed), .job_sum(job_sum), .job_sumsq(job_sumsq),
    .job_min(job_min), .job_max(job_max), .job_count(job_count),
    .job_instant(job_instant), .res_push(res_push), .res_data(res_data),
    .res_full(res_full)
  );

  wss_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(res_push), .push_data(res_data), .full(res_full),
    .pop(pop), .empty(empty), .pop_data(out_data)
  );

  `WSS_ASSERT_IMPL(a_closed_count, clk, rst_n,
    !empty && out_data.window_closed, out_data.sample_count != 8'd0)
  `WSS_ASSERT_IMPL(a_open_zero, clk, rst_n,
    !empty && !out_data.window_closed, out_data.sample_count == 8'd0)
  `WSS_ASSERT_NEXT(a_take_busy, clk, rst_n, push && !full, full)
endmodule

@@ sim/tb_windowed_signal_statistics_top.sv @@
// ----------------------------------------------------------------------------
// Windowed signal statistics testbench
// Drives timestamped samples through several window lengths and checks every
// result against an in-bench model of the tumbling window statistics.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_windowed_signal_statistics_top;
  import wss_pkg::*;

  localparam int unsigned Depth = 128;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        push = 1'b0;
  in_req_t     in_data = '0;
  logic        full;
  logic        empty;
  logic        pop = 1'b0;
  out_req_t    out_data;

  windowed_signal_statistics_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .push     (push),
    .in_data  (in_data),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  in_req_t  pending_samples[$];
  out_req_t expected_stats[$];

  logic signed [15:0] win_samples[Depth];
  int unsigned        wr_ptr = 0;
  int unsigned        held = 0;
  logic [31:0]        win_start = '0;
  logic               have_start = 1'b0;
  logic [31:0]        win_len = WindowTicksReset;

  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_closes = 0;
  int unsigned n_errors = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic [31:0] t_now = 32'd10;

  function automatic logic [15:0] floor_sqrt(longint unsigned v);
    longint unsigned r;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v) r = r | (64'd1 << b);
    end
    return r[15:0];
  endfunction

  function automatic out_req_t window_stats(in_req_t s);
    out_req_t        r;
    longint          sum;
    longint unsigned sumsq;
    int              lo;
    int              hi;
    int              v;
    r = '0;
    if (!have_start) begin
      win_start = s.sample_time;
      have_start = 1'b1;
    end
    if (held > 0 && s.sample_time >= win_start &&
        (s.sample_time - win_start) >= win_len) begin
      sum = 0;
      sumsq = 0;
      lo = 32767;
      hi = -32768;
      for (int i = 0; i < held; i++) begin
        v = win_samples[(wr_ptr + Depth - held + i) % Depth];
        sum += v;
        sumsq += longint'(v) * longint'(v);
        if (v < lo) lo = v;
        if (v > hi) hi = v;
      end
      r.window_closed = 1'b1;
      r.mean_value = 16'(sum / longint'(held));
      r.rms_value = floor_sqrt(sumsq / held);
      r.min_value = 16'(lo);
      r.max_value = 16'(hi);
      r.sample_count = 8'(held);
      win_start = win_start + win_len;
      wr_ptr = 0;
      held = 0;
    end
    win_samples[wr_ptr] = s.sample_value;
    wr_ptr = (wr_ptr + 1) % Depth;
    if (held < Depth) held++;
    r.instant_value = s.sample_value;
    return r;
  endfunction

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(0, 40)) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_sample(logic [31:0] t, logic signed [15:0] v);
    in_req_t s;
    s.sample_time = t;
    s.sample_value = v;
    pending_samples.push_back(s);
  endtask

  task automatic add_random(int unsigned n, int unsigned max_step, logic [31:0] big_step);
    for (int i = 0; i < n; i++) begin
      if (big_step != 0 && $urandom_range(0, 3) == 0) t_now = t_now + ($urandom % big_step);
      else t_now = t_now + $urandom_range(0, max_step);
      add_sample(t_now, pick_value());
    end
  endtask

  task automatic drain_and_write(logic [31:0] len);
    while (pending_samples.size() != 0 || push || expected_stats.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_len = len;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) begin
        expected_stats.push_back(window_stats(in_data));
        void'(pending_samples.pop_front());
        n_sent++;
      end
      if (pending_samples.size() != 0 &&
          ((n_sent > 400 && n_sent < 500) || $urandom_range(0, 99) >= 23)) begin
        push <= 1'b1;
        in_data <= pending_samples[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) begin
        if (expected_stats.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("Unexpected result %p", out_data);
        end else begin
          if (out_data !== expected_stats[0]) begin
            n_errors++;
            if (n_errors <= 10)
              $display("Mismatch at result %0d: expected %p, got %p",
                       n_checked, expected_stats[0], out_data);
          end
          if (expected_stats[0].window_closed) n_closes++;
          void'(expected_stats.pop_front());
        end
        n_checked++;
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else if (n_checked == 100 && !hold_done) begin
        hold_left <= 300;
        hold_done <= 1'b1;
        pop <= 1'b0;
      end else begin
        pop <= (n_checked > 400 && n_checked < 500) || $urandom_range(0, 99) >= 23;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Timeout waiting for results");
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    add_sample(32'd10, 16'sh7FFF);
    add_sample(32'd10, 16'sh8000);
    add_sample(32'd50, 16'sh0000);
    add_sample(32'd109, -16'sd1);
    add_sample(32'd110, 16'sd1);
    add_sample(32'd5, 16'sh5555);
    add_sample(32'd300, 16'shAAAA);
    add_sample(32'd300, -16'sd3);
    add_sample(32'd400, 16'sd3);
    add_sample(32'd500, -16'sd7);
    add_sample(32'd501, 16'sd2);
    add_sample(32'd620, 16'sh8000);
    add_sample(32'd620, 16'sh8000);
    add_sample(32'd900, 16'sh7FFF);
    add_sample(32'd1000, 16'sd0);
    t_now = 32'd1000;
    add_random(150, 20, 0);
    drain_and_write(32'd1);
    add_random(100, 2, 0);
    drain_and_write(32'd1000);
    add_random(200, 3, 0);
    drain_and_write(32'hC000_0000);
    add_random(60, 5, 32'h8000_0000);
    drain_and_write(32'hFFFF_FFFF);
    add_random(20, 3, 32'hFFFF_FFFF);
    drain_and_write(32'd50);
    add_random(150, 10, 0);
    while (pending_samples.size() != 0 || push || expected_stats.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("Checked %0d results from %0d samples, %0d of them window closes,",
             n_checked, n_sent, n_closes);
    $display("over six window lengths including 1 and the largest; %0d mismatches.",
             n_errors);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+src
src/wss_pkg.sv
src/wss_ram.sv
src/wss_fifo.sv
src/wss_front.sv
src/wss_back.sv
src/windowed_signal_statistics_top.sv
sim/tb_windowed_signal_statistics_top.sv
